/* design/slto_pkg.sv */
// ----------------------------------------------------------------------------
// slto_pkg
// shared types, command codes and the divide-by-125 digit step
// ----------------------------------------------------------------------------
package slto_pkg;

  localparam logic [2:0] CMD_TICK       = 3'd0;
  localparam logic [2:0] CMD_SET_STEADY = 3'd1;
  localparam logic [2:0] CMD_SET_TEMP   = 3'd2;
  localparam logic [2:0] CMD_ALL_STEADY = 3'd3;
  localparam logic [2:0] CMD_ALL_TEMP   = 3'd4;

  localparam int          DIV_STEPS    = 4;
  localparam int          DIGIT_W      = 16;
  localparam int          NSTG         = DIV_STEPS + 2;
  localparam logic [25:0] RECIP_125    = 26'd34359739;
  localparam logic [25:0] US_PER_MS    = 26'd1000;
  localparam logic [25:0] LIMIT_RESET  = 26'd10000;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [4:0]  channel;
    logic [31:0] value;
    logic [31:0] override_ms;
    logic        taken;
    logic [63:0] num;
    logic [6:0]  rem;
    logic [31:0] quo;
  } slto_stage_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [4:0]  channel;
    logic [31:0] value;
    logic [31:0] override_ms;
    logic        taken;
    logic [31:0] period;
  } slto_op_t;

  // one radix 2^16 long-division digit by 125: returns {quotient digit, remainder}
  function automatic logic [22:0] div125_step(input logic [6:0] rem,
                                              input logic [DIGIT_W-1:0] digit);
    logic [22:0] v;
    logic [48:0] prod;
    logic [15:0] q;
    logic [22:0] qm;
    logic [6:0]  r;
    v    = {rem, digit};
    prod = 49'(v) * 49'(RECIP_125);
    q    = prod[47:32];
    qm   = 23'({q, 7'b0}) - 23'({q, 1'b0}) - 23'(q);
    r    = 7'(v - qm);
    return {q, r};
  endfunction

endpackage

/* design/slto_if.sv */
// ----------------------------------------------------------------------------
// slto channel interfaces
// valid/ready channels for items, results and the interval register write
// ----------------------------------------------------------------------------
interface slto_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [63:0] time_now_us;
  logic [4:0]  channel;
  logic [31:0] value;
  logic [31:0] override_ms;

  modport source (output valid, cmd, time_now_us, channel, value, override_ms, input ready);
  modport sink   (input valid, cmd, time_now_us, channel, value, override_ms, output ready);
endinterface

interface slto_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] level_mask;
  logic        tick_taken;

  modport source (output valid, level_mask, tick_taken, input ready);
  modport sink   (input valid, level_mask, tick_taken, output ready);
endinterface

interface slto_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] tick_interval_ms;

  modport source (output valid, tick_interval_ms, input ready);
  modport sink   (input valid, tick_interval_ms, output ready);
endinterface

/* design/signal_levels_with_timed_override.sv */
// ----------------------------------------------------------------------------
// signal_levels_with_timed_override
// one-bit output channels with steady levels and timed temporary overrides
//
//   port      dir   carries
//   in_item   sink  cmd, time_now_us, channel, value, override_ms
//   out_item  src   level_mask, tick_taken
//   cfg_wr    sink  tick_interval_ms
//
// one item per cycle sustained while out_item is ready; each item passes
// from the input register through the elapsed/interval check, four
// digit steps of the divide-by-1000 for the tick period, then the channel
// update into the result register. stages advance independently, so bubbles
// are absorbed and a waiting result does not stop intake until the pipeline
// is full. synchronous active-low reset clears all channel state and the
// tick time.
// ----------------------------------------------------------------------------
module signal_levels_with_timed_override #(
  parameter int CHANNELS = 8
) (
  input  logic clk,
  input  logic rst_n,
  slto_in_if.sink    in_item,
  slto_out_if.source out_item,
  slto_cfg_if.sink   cfg_wr
);
  import slto_pkg::*;

  slto_stage_t stg_r   [NSTG];
  slto_stage_t stg_nxt [NSTG];
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] mv;
  logic [NSTG:0]   room;
  logic [63:0]     last_r;
  logic [25:0]     limit_r;
  logic [63:0]     elapsed;
  logic            out_valid_r;
  logic [31:0]     out_mask_r;
  logic            out_taken_r;
  logic [31:0]     mask_nxt;
  logic            in_acc;
  slto_op_t        op;

  always_comb begin
    room[NSTG] = !out_valid_r || out_item.ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      mv[k]   = vld_r[k] && room[k+1];
      room[k] = !vld_r[k] || mv[k];
    end
  end

  assign in_item.ready = room[0];
  assign in_acc        = in_item.valid && room[0];
  assign cfg_wr.ready  = 1'b1;

  assign elapsed = stg_r[0].num - last_r;

  always_comb begin
    logic [22:0] qr;
    stg_nxt[0].cmd         = in_item.cmd;
    stg_nxt[0].channel     = in_item.channel;
    stg_nxt[0].value       = in_item.value;
    stg_nxt[0].override_ms = in_item.override_ms;
    stg_nxt[0].taken       = 1'b0;
    stg_nxt[0].num         = in_item.time_now_us;
    stg_nxt[0].rem         = '0;
    stg_nxt[0].quo         = '0;

    stg_nxt[1]       = stg_r[0];
    stg_nxt[1].taken = (stg_r[0].cmd == CMD_TICK) && (elapsed > 64'(limit_r));
    stg_nxt[1].num   = {3'b0, elapsed[63:3]};

    for (int k = 1; k <= DIV_STEPS; k++) begin
      qr             = div125_step(stg_r[k].rem,
                                   stg_r[k].num[DIGIT_W*(DIV_STEPS-k) +: DIGIT_W]);
      stg_nxt[k+1]     = stg_r[k];
      stg_nxt[k+1].quo = {stg_r[k].quo[15:0], qr[22:7]};
      stg_nxt[k+1].rem = qr[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r[0] <= in_acc || (vld_r[0] && !mv[0]);
      for (int k = 1; k < NSTG; k++) begin
        vld_r[k] <= mv[k-1] || (vld_r[k] && !mv[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) stg_r[0] <= stg_nxt[0];
    for (int k = 1; k < NSTG; k++) begin
      if (mv[k-1]) stg_r[k] <= stg_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
    end else if (mv[0] && stg_nxt[1].taken) begin
      last_r <= stg_r[0].num;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr.valid) begin
      limit_r <= 26'(26'(cfg_wr.tick_interval_ms) * US_PER_MS);
    end
  end

  assign op.cmd         = stg_r[NSTG-1].cmd;
  assign op.channel     = stg_r[NSTG-1].channel;
  assign op.value       = stg_r[NSTG-1].value;
  assign op.override_ms = stg_r[NSTG-1].override_ms;
  assign op.taken       = stg_r[NSTG-1].taken;
  assign op.period      = stg_r[NSTG-1].quo;

  slto_chan_bank #(
    .CHANNELS (CHANNELS)
  ) u_bank (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_en    (mv[NSTG-1]),
    .op       (op),
    .mask_nxt (mask_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= mv[NSTG-1] || (out_valid_r && !out_item.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (mv[NSTG-1]) begin
      out_mask_r  <= mask_nxt;
      out_taken_r <= op.taken;
    end
  end

  assign out_item.valid      = out_valid_r;
  assign out_item.level_mask = out_mask_r;
  assign out_item.tick_taken = out_taken_r;

endmodule

/* design/slto_chan_bank.sv */
// ----------------------------------------------------------------------------
// slto_chan_bank
// per-channel steady/temporary levels, override countdown and output levels
// ----------------------------------------------------------------------------
module slto_chan_bank #(
  parameter int CHANNELS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             op_en,
  input  slto_pkg::slto_op_t op,
  output logic [31:0]      mask_nxt
);
  import slto_pkg::*;

  logic [CHANNELS-1:0] steady_r, steady_nxt;
  logic [CHANNELS-1:0] temp_r, temp_nxt;
  logic [CHANNELS-1:0] cur_r, cur_nxt;
  logic [31:0]         remain_r [CHANNELS];
  logic [31:0]         remain_nxt [CHANNELS];
  logic                ch_ok;

  assign ch_ok = {1'b0, op.channel} < 6'(CHANNELS);

  always_comb begin
    steady_nxt = steady_r;
    temp_nxt   = temp_r;
    cur_nxt    = cur_r;
    for (int i = 0; i < CHANNELS; i++) begin
      remain_nxt[i] = remain_r[i];
    end
    if (op_en) begin
      case (op.cmd)
        CMD_TICK: begin
          if (op.taken) begin
            for (int i = 0; i < CHANNELS; i++) begin
              if (remain_r[i] != 32'd0) begin
                remain_nxt[i] = (remain_r[i] >= op.period) ? remain_r[i] - op.period : 32'd0;
                cur_nxt[i]    = temp_r[i];
              end else begin
                cur_nxt[i] = steady_r[i];
              end
            end
          end
        end
        CMD_SET_STEADY: begin
          for (int i = 0; i < CHANNELS; i++) begin
            if (ch_ok && op.channel == 5'(i)) steady_nxt[i] = op.value[0];
          end
        end
        CMD_SET_TEMP: begin
          for (int i = 0; i < CHANNELS; i++) begin
            if (ch_ok && op.channel == 5'(i)) begin
              temp_nxt[i]   = op.value[0];
              remain_nxt[i] = op.override_ms;
            end
          end
        end
        CMD_ALL_STEADY: begin
          for (int i = 0; i < CHANNELS; i++) begin
            steady_nxt[i] = op.value[i];
          end
        end
        CMD_ALL_TEMP: begin
          for (int i = 0; i < CHANNELS; i++) begin
            temp_nxt[i]   = op.value[i];
            remain_nxt[i] = op.override_ms;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    mask_nxt = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      mask_nxt[i] = cur_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steady_r <= '0;
      temp_r   <= '0;
      cur_r    <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        remain_r[i] <= '0;
      end
    end else begin
      steady_r <= steady_nxt;
      temp_r   <= temp_nxt;
      cur_r    <= cur_nxt;
      for (int i = 0; i < CHANNELS; i++) begin
        remain_r[i] <= remain_nxt[i];
      end
    end
  end

endmodule
